/* src/pdtr_pkg.sv */
// ----------------------------------------------------------------------------
// pdtr_pkg: shared types and constants for the trapezoid duty ramp
// Field widths, phase and opcode codes, register indexes and the
// control/status structs that pass between the top level and the divider.
// ----------------------------------------------------------------------------
`default_nettype none

package pdtr_pkg;

  // Field widths
  localparam int DUTY_W = 16;
  localparam int STEP_W = 10;
  localparam int MODE_W = 2;
  localparam int CNT_W  = $clog2(DUTY_W + 1);

  // Hold length of the long test
  localparam logic [STEP_W-1:0] LONG_HOLD = STEP_W'(60);

  // Register indexes on the configuration port
  localparam logic REG_FLOOR   = 1'b0;
  localparam logic REG_CEILING = 1'b1;

  // Test modes
  localparam logic [MODE_W-1:0] MODE_SHORT    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LONG     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_THROTTLE = 2'd2;
  localparam logic [MODE_W-1:0] MODE_UNUSED   = 2'd3;

  // Item opcodes
  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_START = 1'b1
  } op_t;

  // Profile phase, as reported on phase_now
  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_RISE = 2'd1,
    PH_HOLD = 2'd2,
    PH_FALL = 2'd3
  } phase_t;

  // Control sequencer of the top level
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_DIV_UP,
    CS_DIV_DN
  } ctl_state_t;

  // Divider request and response
  typedef struct packed {
    logic              start;
    logic [DUTY_W-1:0] dividend;
    logic [STEP_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DUTY_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

/* src/pdtr_in_if.sv */
// ----------------------------------------------------------------------------
// pdtr_in_if: input item channel
// Valid/ready channel carrying one tick or start item per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdtr_in_if;
  import pdtr_pkg::*;

  logic              valid;
  logic              ready;
  logic              opcode;
  logic [MODE_W-1:0] test_mode;
  logic [STEP_W-1:0] rise_steps;
  logic [STEP_W-1:0] hold_seconds;
  logic [STEP_W-1:0] fall_steps;

  modport source (
    output valid, opcode, test_mode, rise_steps, hold_seconds, fall_steps,
    input  ready
  );

  modport sink (
    input  valid, opcode, test_mode, rise_steps, hold_seconds, fall_steps,
    output ready
  );
endinterface

`default_nettype wire

/* src/pdtr_out_if.sv */
// ----------------------------------------------------------------------------
// pdtr_out_if: result channel
// Valid/ready channel carrying one duty/phase result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdtr_out_if;
  import pdtr_pkg::*;

  logic              valid;
  logic              ready;
  logic [DUTY_W-1:0] duty_out;
  logic              busy_res;
  logic [1:0]        phase_now;
  logic              start_rejected;

  modport source (
    output valid, duty_out, busy_res, phase_now, start_rejected,
    input  ready
  );

  modport sink (
    input  valid, duty_out, busy_res, phase_now, start_rejected,
    output ready
  );
endinterface

`default_nettype wire

/* src/pdtr_div.sv */
// ----------------------------------------------------------------------------
// pdtr_div: bit-serial restoring divider
// Divides the duty span by a step count, one quotient bit per cycle.
// The dividend shifts out MSB first while quotient bits shift in.
// ----------------------------------------------------------------------------
`default_nettype none

module pdtr_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pdtr_pkg::div_req_t  req,
  output      pdtr_pkg::div_rsp_t  rsp
);
  import pdtr_pkg::*;

  logic [CNT_W-1:0]  cnt;
  logic [STEP_W-1:0] rem;
  logic [DUTY_W-1:0] quo;
  logic [STEP_W-1:0] dvsr;
  logic              done;

  logic [STEP_W:0]   partial;
  logic [STEP_W:0]   trial;

  // One restoring step: bring down the next dividend bit and try a subtract
  always_comb begin
    partial = {rem, quo[DUTY_W-1]};
    trial   = partial - {1'b0, dvsr};
  end

  // Iteration counter and done pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (req.start) begin
      cnt  <= CNT_W'(DUTY_W);
      done <= 1'b0;
    end else if (cnt != '0) begin
      cnt  <= cnt - 1'b1;
      done <= (cnt == CNT_W'(1));
    end else begin
      done <= 1'b0;
    end
  end

  // Datapath shift registers
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= '0;
      quo  <= req.dividend;
      dvsr <= req.divisor;
    end else if (cnt != '0) begin
      if (trial[STEP_W]) begin
        rem <= partial[STEP_W-1:0];
        quo <= {quo[DUTY_W-2:0], 1'b0};
      end else begin
        rem <= trial[STEP_W-1:0];
        quo <= {quo[DUTY_W-2:0], 1'b1};
      end
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

/* src/pwm_duty_trapezoid_ramp.sv */
// ----------------------------------------------------------------------------
// pwm_duty_trapezoid_ramp: trapezoidal PWM duty profile generator
// Rises, holds and falls a duty value, stepped by one-second tick items.
// ----------------------------------------------------------------------------
// Usage:
//   din carries items: opcode 1 starts a profile (mode, rise, hold and fall
//   counts), opcode 0 is a one-second tick. dout returns exactly one result
//   per item: duty, busy flag, phase and a start-rejected flag.
//   cfg_we/cfg_index/cfg_data write duty_floor (index 0) and duty_ceiling
//   (index 1); write them only while no result is pending.
// Timing:
//   A tick, a rejected start or a mode-three start is handled in the cycle
//   it is accepted; its result is valid on the next cycle.
//   An accepted start runs two serial divisions on one shared bit-serial
//   divider, for the rise and fall increments, before its result is
//   loaded. Only one item is in flight at a time.
// Reset:
//   rst clears the phase to idle, duty and increments to zero and the
//   registers to floor 0 and ceiling 65535. No result is pending.
// Stall:
//   A result waits in the output register while dout.ready is low; din
//   is still accepted in the cycle the waiting result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_duty_trapezoid_ramp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  pdtr_in_if.sink                          din,
  pdtr_out_if.source                       dout,
  input  wire logic                        cfg_we,
  input  wire logic                        cfg_index,
  input  wire logic [pdtr_pkg::DUTY_W-1:0] cfg_data
);
  import pdtr_pkg::*;

  // Configuration registers
  logic [DUTY_W-1:0] duty_floor;
  logic [DUTY_W-1:0] duty_ceiling;

  // Profile state
  ctl_state_t        ctl_state, ctl_state_next;
  phase_t            phase_reg, phase_reg_next;
  logic [STEP_W-1:0] step_left, step_left_next;
  logic [DUTY_W-1:0] up_increment, up_increment_next;
  logic [DUTY_W-1:0] down_increment, down_increment_next;
  logic [DUTY_W-1:0] duty_reg, duty_reg_next;
  logic [STEP_W-1:0] hold_len, hold_len_next;
  logic [STEP_W-1:0] fall_len, fall_len_next;

  // Output register
  logic              out_valid;
  logic [DUTY_W-1:0] out_duty;
  phase_t            out_phase;
  logic              out_rejected;

  logic              in_acc;
  logic              load_out;
  logic              rejected;
  logic [DUTY_W-1:0] top_duty;
  logic [DUTY_W:0]   rise_sum;
  logic [DUTY_W:0]   fall_diff;
  logic [STEP_W-1:0] div_steps;
  logic [STEP_W-1:0] hold_sel;
  logic              div_start;

  div_req_t          div_req;
  div_rsp_t          div_rsp;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_floor   <= '0;
      duty_ceiling <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FLOOR:   duty_floor   <= cfg_data;
        REG_CEILING: duty_ceiling <= cfg_data;
        default:     duty_floor   <= duty_floor;
      endcase
    end
  end

  // Handshake
  assign din.ready = (ctl_state == CS_IDLE) && (!out_valid || dout.ready);
  assign in_acc    = din.valid && din.ready;

  // Ramp arithmetic
  always_comb begin
    top_duty  = (duty_ceiling > duty_floor) ? duty_ceiling : duty_floor;
    rise_sum  = {1'b0, duty_reg} + {1'b0, up_increment};
    fall_diff = {1'b0, duty_reg} - {1'b0, duty_floor};
  end

  // Hold length by mode
  always_comb begin
    case (din.test_mode)
      MODE_SHORT: hold_sel = din.hold_seconds;
      MODE_LONG:  hold_sel = LONG_HOLD;
      default:    hold_sel = '0;
    endcase
  end

  // Divider request: span over (steps - 1), whole span below two steps
  always_comb begin
    div_steps        = (ctl_state == CS_IDLE) ? din.rise_steps : fall_len;
    div_req.start    = div_start;
    div_req.dividend = top_duty - duty_floor;
    div_req.divisor  = (div_steps < STEP_W'(2)) ? STEP_W'(1) : div_steps - 1'b1;
  end

  pdtr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // Sequencer and profile next state
  always_comb begin
    ctl_state_next      = ctl_state;
    phase_reg_next      = phase_reg;
    step_left_next      = step_left;
    up_increment_next   = up_increment;
    down_increment_next = down_increment;
    duty_reg_next       = duty_reg;
    hold_len_next       = hold_len;
    fall_len_next       = fall_len;
    load_out            = 1'b0;
    rejected            = 1'b0;
    div_start           = 1'b0;

    case (ctl_state)
      CS_IDLE: begin
        if (in_acc) begin
          load_out = 1'b1;
          if (op_t'(din.opcode) == OP_START) begin
            if (phase_reg != PH_IDLE) begin
              rejected = 1'b1;
            end else begin
              duty_reg_next = duty_floor;
              if (din.test_mode != MODE_UNUSED) begin
                hold_len_next  = hold_sel;
                fall_len_next  = din.fall_steps;
                step_left_next = din.rise_steps;
                phase_reg_next = PH_RISE;
                div_start      = 1'b1;
                ctl_state_next = CS_DIV_UP;
                load_out       = 1'b0;
              end
            end
          end else begin
            case (phase_reg)
              PH_RISE: begin
                duty_reg_next = (rise_sum > {1'b0, top_duty}) ?
                                top_duty : rise_sum[DUTY_W-1:0];
                if (step_left == '0) begin
                  if (hold_len == '0) begin
                    phase_reg_next = PH_FALL;
                    step_left_next = fall_len;
                  end else begin
                    phase_reg_next = PH_HOLD;
                    step_left_next = hold_len;
                  end
                end else begin
                  step_left_next = step_left - 1'b1;
                end
              end
              PH_HOLD: begin
                // fall begins on the tick that empties the hold count
                if (step_left <= STEP_W'(1)) begin
                  phase_reg_next = PH_FALL;
                  step_left_next = fall_len;
                end else begin
                  step_left_next = step_left - 1'b1;
                end
              end
              PH_FALL: begin
                if (fall_diff[DUTY_W] || (fall_diff[DUTY_W-1:0] < down_increment)) begin
                  duty_reg_next = duty_floor;
                end else begin
                  duty_reg_next = duty_reg - down_increment;
                end
                if (step_left == '0) begin
                  phase_reg_next = PH_IDLE;
                end else begin
                  step_left_next = step_left - 1'b1;
                end
              end
              default: begin
                phase_reg_next = PH_IDLE;
              end
            endcase
          end
        end
      end
      CS_DIV_UP: begin
        if (div_rsp.done) begin
          up_increment_next = div_rsp.quotient;
          div_start         = 1'b1;
          ctl_state_next    = CS_DIV_DN;
        end
      end
      CS_DIV_DN: begin
        if (div_rsp.done) begin
          down_increment_next = div_rsp.quotient;
          load_out            = 1'b1;
          ctl_state_next      = CS_IDLE;
        end
      end
      default: begin
        ctl_state_next = CS_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_state      <= CS_IDLE;
      phase_reg      <= PH_IDLE;
      step_left      <= '0;
      up_increment   <= '0;
      down_increment <= '0;
      duty_reg       <= '0;
      hold_len       <= '0;
      fall_len       <= '0;
    end else begin
      ctl_state      <= ctl_state_next;
      phase_reg      <= phase_reg_next;
      step_left      <= step_left_next;
      up_increment   <= up_increment_next;
      down_increment <= down_increment_next;
      duty_reg       <= duty_reg_next;
      hold_len       <= hold_len_next;
      fall_len       <= fall_len_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_duty     <= duty_reg_next;
      out_phase    <= phase_reg_next;
      out_rejected <= rejected;
    end
  end

  assign dout.valid          = out_valid;
  assign dout.duty_out       = out_duty;
  assign dout.phase_now      = out_phase;
  assign dout.busy_res       = (out_phase != PH_IDLE);
  assign dout.start_rejected = out_rejected;

  // Checks
  a_div_done_result: assert property (@(posedge clk) disable iff (rst)
    (ctl_state == CS_DIV_DN && div_rsp.done) |=> (out_valid && out_phase == PH_RISE))
    else $error("start result not presented after second division");

  a_reject_keeps_phase: assert property (@(posedge clk) disable iff (rst)
    (in_acc && din.opcode == OP_START && phase_reg != PH_IDLE) |=>
      ($stable(phase_reg) && out_rejected))
    else $error("rejected start disturbed the profile");

  a_no_input_while_dividing: assert property (@(posedge clk) disable iff (rst)
    (ctl_state != CS_IDLE) |-> (!din.ready && !load_out || div_rsp.done))
    else $error("item accepted or result loaded during division");

endmodule

`default_nettype wire

/* test/pwm_duty_trapezoid_ramp_tb.sv */
// ----------------------------------------------------------------------------
// pwm_duty_trapezoid_ramp_tb: self-checking bench for the trapezoid duty ramp
// Drives start and tick transactions through the valid/ready input channel
// and checks every result against a cycle-free profile predictor. It runs
// several floor/ceiling settings, including a ceiling below the floor,
// applies random input gaps, output backpressure and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_duty_trapezoid_ramp_tb;
  import pdtr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 95;
  localparam int STALL_AT       = 300;
  localparam int STALL_CYCLES   = 150;

  typedef struct {
    op_t               op;
    logic [MODE_W-1:0] mode;
    logic [STEP_W-1:0] rise;
    logic [STEP_W-1:0] hold;
    logic [STEP_W-1:0] fall;
  } ramp_cmd_t;

  typedef struct {
    logic [DUTY_W-1:0] duty;
    logic              busy;
    phase_t            phase;
    logic              rejected;
  } duty_result_t;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic              cfg_index;
  logic [DUTY_W-1:0] cfg_data;

  pdtr_in_if  cmd_ch ();
  pdtr_out_if res_ch ();

  pwm_duty_trapezoid_ramp i_dut (
    .clk       (clk),
    .rst       (rst),
    .din       (cmd_ch),
    .dout      (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Pending commands and expected results
  ramp_cmd_t    cmd_q[$];
  duty_result_t expected_duty_q[$];
  ramp_cmd_t    cmd_on_bus;

  // Predictor copy of the profile state and the limits
  phase_t            prof_phase;
  logic [STEP_W-1:0] prof_steps_left;
  logic [DUTY_W-1:0] prof_inc_up;
  logic [DUTY_W-1:0] prof_inc_down;
  logic [DUTY_W-1:0] prof_duty;
  logic [STEP_W-1:0] prof_hold_len;
  logic [STEP_W-1:0] prof_fall_len;
  logic [DUTY_W-1:0] lim_floor;
  logic [DUTY_W-1:0] lim_ceiling;

  int unsigned cmds_issued;
  int unsigned results_checked;
  int unsigned phase_items;
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned gap_left;
  int unsigned calm_left;
  int unsigned ready_gap;
  int unsigned hold_off_left;
  logic        quiet;

  // Clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (error_count < 50)
      $display("mismatch on %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // Effective top of the ramp: never below the floor
  function automatic logic [DUTY_W-1:0] ramp_top();
    return (lim_ceiling > lim_floor) ? lim_ceiling : lim_floor;
  endfunction

  // Span split over (steps - 1); a count below two takes the whole span
  function automatic logic [DUTY_W-1:0] ramp_increment(input logic [STEP_W-1:0] steps);
    int unsigned span;
    span = ramp_top() - lim_floor;
    if (steps < 2)
      return DUTY_W'(span);
    return DUTY_W'(span / (steps - 1));
  endfunction

  // Advance the profile by one accepted transaction and queue its result
  task automatic advance_profile(input ramp_cmd_t c);
    duty_result_t r;
    logic [DUTY_W:0] sum;
    r.rejected = 1'b0;
    if (c.op == OP_START) begin
      if (prof_phase != PH_IDLE) begin
        r.rejected = 1'b1;
      end else begin
        prof_duty = lim_floor;
        if (c.mode != MODE_UNUSED) begin
          prof_inc_up   = ramp_increment(c.rise);
          prof_inc_down = ramp_increment(c.fall);
          case (c.mode)
            MODE_SHORT: prof_hold_len = c.hold;
            MODE_LONG:  prof_hold_len = LONG_HOLD;
            default:    prof_hold_len = '0;
          endcase
          prof_fall_len   = c.fall;
          prof_steps_left = c.rise;
          prof_phase      = PH_RISE;
        end
      end
    end else begin
      case (prof_phase)
        PH_RISE: begin
          sum = {1'b0, prof_duty} + {1'b0, prof_inc_up};
          prof_duty = (sum > {1'b0, ramp_top()}) ? ramp_top() : sum[DUTY_W-1:0];
          if (prof_steps_left == 0) begin
            if (prof_hold_len == 0) begin
              prof_phase      = PH_FALL;
              prof_steps_left = prof_fall_len;
            end else begin
              prof_phase      = PH_HOLD;
              prof_steps_left = prof_hold_len;
            end
          end else begin
            prof_steps_left--;
          end
        end
        PH_HOLD: begin
          // falling is entered on the last hold tick itself
          if (prof_steps_left != 0)
            prof_steps_left--;
          if (prof_steps_left == 0) begin
            prof_phase      = PH_FALL;
            prof_steps_left = prof_fall_len;
          end
        end
        PH_FALL: begin
          if (prof_duty < lim_floor || prof_duty - lim_floor < prof_inc_down)
            prof_duty = lim_floor;
          else
            prof_duty = prof_duty - prof_inc_down;
          if (prof_steps_left == 0)
            prof_phase = PH_IDLE;
          else
            prof_steps_left--;
        end
        default: ;
      endcase
    end
    r.duty  = prof_duty;
    r.busy  = (prof_phase != PH_IDLE);
    r.phase = prof_phase;
    expected_duty_q.push_back(r);
  endtask

  // Input driver
  always @(posedge clk) begin : drive
    ramp_cmd_t nxt;
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      gap_left = 0;
      calm_left = 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready)
        advance_profile(cmd_on_bus);
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          nxt = cmd_q.pop_front();
          cmd_on_bus = nxt;
          cmds_issued++;
          cmd_ch.valid        <= 1'b1;
          cmd_ch.opcode       <= nxt.op;
          cmd_ch.test_mode    <= nxt.mode;
          cmd_ch.rise_steps   <= nxt.rise;
          cmd_ch.hold_seconds <= nxt.hold;
          cmd_ch.fall_steps   <= nxt.fall;
          // idle bursts, with occasional calm stretches
          if (calm_left > 0)
            calm_left--;
          else if ($urandom_range(0, 40) == 0)
            calm_left = $urandom_range(20, 60);
          else if (!quiet && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 5);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and ready generator
  always @(posedge clk) begin : collect
    duty_result_t want;
    if (rst) begin
      res_ch.ready <= 1'b0;
      ready_gap = 0;
      hold_off_left = 0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        results_checked++;
        if (expected_duty_q.size() == 0) begin
          report_mismatch("result with no pending transaction", res_ch.duty_out, 0);
        end else begin
          want = expected_duty_q.pop_front();
          if (res_ch.duty_out !== want.duty)
            report_mismatch("duty_out", res_ch.duty_out, want.duty);
          if (res_ch.busy_res !== want.busy)
            report_mismatch("busy_res", res_ch.busy_res, want.busy);
          if (res_ch.phase_now !== 2'(want.phase))
            report_mismatch("phase_now", res_ch.phase_now, want.phase);
          if (res_ch.start_rejected !== want.rejected)
            report_mismatch("start_rejected", res_ch.start_rejected, want.rejected);
        end
        // one long stall so the block backs up into its input
        if (results_checked == STALL_AT)
          hold_off_left = STALL_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        res_ch.ready <= 1'b0;
      end else if (ready_gap > 0) begin
        ready_gap--;
        res_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        ready_gap = $urandom_range(0, 4);
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [STEP_W-1:0] any_count();
    return STEP_W'($urandom_range(0, 999));
  endfunction

  // Mostly short ramps, some medium, a few drawn from the whole 0 to 999 range
  function automatic logic [STEP_W-1:0] ramp_count();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick < 13)
      return STEP_W'($urandom_range(0, 6));
    if (pick < 19)
      return STEP_W'($urandom_range(0, 40));
    return any_count();
  endfunction

  task automatic queue_cmd(input op_t op, input logic [MODE_W-1:0] mode,
                           input logic [STEP_W-1:0] rise, input logic [STEP_W-1:0] hold,
                           input logic [STEP_W-1:0] fall);
    ramp_cmd_t c;
    c.op   = op;
    c.mode = mode;
    c.rise = rise;
    c.hold = hold;
    c.fall = fall;
    cmd_q.push_back(c);
    phase_items++;
  endtask

  task automatic queue_noise();
    queue_cmd(op_t'($urandom_range(0, 1)), MODE_W'($urandom_range(0, 3)),
              any_count(), any_count(), any_count());
  endtask

  // A start followed by ticks to run it out (at most 120), sometimes with a
  // second start arriving mid-profile
  task automatic queue_profile();
    logic [MODE_W-1:0] mode;
    logic [STEP_W-1:0] rise;
    logic [STEP_W-1:0] hold;
    logic [STEP_W-1:0] fall;
    int unsigned       pick;
    int unsigned       hold_ticks;
    int unsigned       ticks;
    int unsigned       intruder;
    pick = $urandom_range(0, 15);
    if (pick < 7)
      mode = MODE_SHORT;
    else if (pick < 9)
      mode = MODE_LONG;
    else if (pick < 15)
      mode = MODE_THROTTLE;
    else
      mode = MODE_UNUSED;
    rise = ramp_count();
    hold = ramp_count();
    fall = ramp_count();
    case (mode)
      MODE_SHORT: hold_ticks = hold;
      MODE_LONG:  hold_ticks = LONG_HOLD;
      default:    hold_ticks = 0;
    endcase
    if (mode == MODE_UNUSED)
      ticks = 1;
    else
      ticks = rise + hold_ticks + fall + 2 + $urandom_range(0, 2);
    if (ticks > 120)
      ticks = 120;
    intruder = ($urandom_range(0, 5) == 0) ? $urandom_range(0, ticks - 1) : ticks;
    queue_cmd(OP_START, mode, rise, hold, fall);
    for (int k = 0; k < ticks; k++) begin
      if (k == intruder)
        queue_cmd(OP_START, MODE_W'($urandom_range(0, 3)), any_count(), any_count(),
                  any_count());
      queue_cmd(OP_TICK, MODE_W'($urandom_range(0, 3)), any_count(), any_count(),
                any_count());
    end
  endtask

  // Directed opening: idle tick, unused mode, single-step profile,
  // rejected start, two-step profile, a throttle profile and a rejected long start
  task automatic queue_directed();
    queue_cmd(OP_TICK, MODE_SHORT, '0, '0, '0);
    queue_cmd(OP_START, MODE_UNUSED, 10'd999, 10'd999, 10'd999);
    queue_cmd(OP_START, MODE_SHORT, '0, '0, '0);
    queue_cmd(OP_START, MODE_THROTTLE, 10'd999, 10'd999, 10'd999);
    repeat (2) queue_cmd(OP_TICK, MODE_UNUSED, 10'd999, 10'd999, 10'd999);
    queue_cmd(OP_START, MODE_SHORT, 10'd1, 10'd1, 10'd1);
    repeat (5) queue_cmd(OP_TICK, MODE_SHORT, '0, '0, '0);
    queue_cmd(OP_START, MODE_THROTTLE, 10'd3, 10'd999, 10'd4);
    repeat (4) queue_cmd(OP_TICK, MODE_SHORT, '0, '0, '0);
    queue_cmd(OP_START, MODE_LONG, 10'd999, '0, 10'd999);
    repeat (6) queue_cmd(OP_TICK, MODE_SHORT, '0, '0, '0);
  endtask

  // Register writes happen only with nothing in flight
  task automatic set_limits(input logic [DUTY_W-1:0] lo, input logic [DUTY_W-1:0] hi);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FLOOR;
    cfg_data  <= lo;
    @(posedge clk);
    cfg_index <= REG_CEILING;
    cfg_data  <= hi;
    @(posedge clk);
    cfg_we    <= 1'b0;
    lim_floor   = lo;
    lim_ceiling = hi;
  endtask

  task automatic wait_drained();
    while (cmd_q.size() != 0 || cmds_issued != results_checked)
      @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Stimulus sequence
  initial begin
    logic [DUTY_W-1:0] floors   [PHASE_COUNT];
    logic [DUTY_W-1:0] ceilings [PHASE_COUNT];
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_FLOOR;
    cfg_data  = '0;
    cmd_ch.valid        = 1'b0;
    cmd_ch.opcode       = OP_TICK;
    cmd_ch.test_mode    = MODE_SHORT;
    cmd_ch.rise_steps   = '0;
    cmd_ch.hold_seconds = '0;
    cmd_ch.fall_steps   = '0;
    res_ch.ready        = 1'b0;
    prof_phase      = PH_IDLE;
    prof_steps_left = '0;
    prof_inc_up     = '0;
    prof_inc_down   = '0;
    prof_duty       = '0;
    prof_hold_len   = '0;
    prof_fall_len   = '0;
    lim_floor       = '0;
    lim_ceiling     = 16'hFFFF;
    cmds_issued     = 0;
    results_checked = 0;
    error_count     = 0;
    idle_cycles     = 0;
    quiet           = 1'b0;

    // full range, mid range, ceiling below floor, zero span at both ends,
    // tiny span, then random settings
    floors   = '{16'd0,     16'd1000,  16'd100, 16'd0, 16'hFFFF, 16'd30000,
                 DUTY_W'($urandom), DUTY_W'($urandom)};
    ceilings = '{16'hFFFF,  16'd60000, 16'd50,  16'd0, 16'hFFFF, 16'd30007,
                 DUTY_W'($urandom), DUTY_W'($urandom)};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < PHASE_COUNT; p++) begin
      if (p == PHASE_COUNT - 1)
        quiet = 1'b1;
      set_limits(floors[p], ceilings[p]);
      phase_items = 0;
      if (p == 0)
        queue_directed();
      while (phase_items < PHASE_ITEMS) begin
        if ($urandom_range(0, 6) == 0)
          queue_noise();
        else
          queue_profile();
      end
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (error_count == 0 && expected_duty_q.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
